[design/modexp_pkg.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, types and constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

    localparam int MOD_BITS       = 31;
    localparam int FIELD_BITS     = 32;
    localparam int OPERAND_BITS_D = 32;
    localparam logic [MOD_BITS-1:0] MODULUS_RESET = 31'h7FFF_FFFF;

    typedef logic [MOD_BITS-1:0] residue_t;

    // One queued job handed from the front to the back.
    typedef struct packed {
        logic [FIELD_BITS-1:0] base_value;
        logic [FIELD_BITS-1:0] exponent_value;
    } job_t;

endpackage

[design/modexp_if.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation channel interfaces
// Valid/ready channels for input jobs and for results.
// ----------------------------------------------------------------------------
interface modexp_in_if;
    logic                                     valid;
    logic                                     ready;
    logic [modexp_pkg::FIELD_BITS-1:0]        base_value;
    logic [modexp_pkg::FIELD_BITS-1:0]        exponent_value;
    modport source (output valid, base_value, exponent_value, input ready);
    modport sink (input valid, base_value, exponent_value, output ready);
endinterface

interface modexp_out_if;
    logic                                     valid;
    logic                                     ready;
    logic [modexp_pkg::MOD_BITS-1:0]          power_result;
    modport source (output valid, power_result, input ready);
    modport sink (input valid, power_result, output ready);
endinterface

[design/modexp_front.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation front end
// Accepts beats, masks operands and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module modexp_front #(
    parameter int OPERAND_BITS = modexp_pkg::OPERAND_BITS_D
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  modexp_pkg::job_t   in_job,
    output logic               job_valid,
    input  logic               job_ready,
    output modexp_pkg::job_t   job
);
    localparam int FB = modexp_pkg::FIELD_BITS;
    localparam logic [FB-1:0] OP_MASK = (OPERAND_BITS >= FB) ? {FB{1'b1}}
        : FB'((64'd1 << OPERAND_BITS) - 64'd1);

    modexp_pkg::job_t q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign job_valid = (count_reg != 2'd0);
    assign job       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = job_valid && job_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg].base_value     <= in_job.base_value & OP_MASK;
            q_reg[wr_ptr_reg].exponent_value <= in_job.exponent_value & OP_MASK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 |-> !push) else $error("push into full queue");
    a_pop_step: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> count_reg == $past(count_reg) - 2'd1)
        else $error("queue count did not drop on pop");

endmodule

[design/modexp_back.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation back end
// Square-and-multiply sequencer around a bit-serial modular multiplier.
// ----------------------------------------------------------------------------
module modexp_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  modexp_pkg::residue_t     modulus,
    input  logic                     job_valid,
    output logic                     job_ready,
    input  modexp_pkg::job_t         job,
    output logic                     out_valid,
    input  logic                     out_ready,
    output modexp_pkg::residue_t     power_result
);
    localparam int MB = modexp_pkg::MOD_BITS;
    localparam int FB = modexp_pkg::FIELD_BITS;
    localparam int CB = $clog2(FB + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SQR  = 3'd3;
    localparam logic [2:0] S_NEXT = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]    state_reg;
    logic [MB-1:0] m_reg, acc_reg, pw_reg;
    logic [FB-1:0] exp_reg, mplier_reg;
    logic [MB-1:0] mcand_reg;
    logic [MB:0]   part_reg;
    logic [CB-1:0] cnt_reg;
    logic [MB-1:0] res_reg;
    logic          res_valid_reg;

    // One bit-serial step: part = 2*part + bit*mcand, reduced twice at most.
    logic [MB+1:0] dbl, add, sub1, fin;
    logic [MB-1:0] step_out;
    always_comb
    begin
        dbl  = {part_reg, 1'b0};
        if (dbl >= {2'b0, m_reg})
            dbl = dbl - {2'b0, m_reg};
        add  = dbl + (mplier_reg[FB-1] ? {2'b0, mcand_reg} : '0);
        sub1 = (add >= {2'b0, m_reg}) ? add - {2'b0, m_reg} : add;
        fin  = sub1;
        step_out = fin[MB-1:0];
    end

    logic last_bit;
    assign last_bit  = (cnt_reg == CB'(1));
    assign job_ready = (state_reg == S_IDLE);
    assign out_valid = res_valid_reg;
    assign power_result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (out_valid && out_ready && state_reg != S_DONE)
                res_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        m_reg      <= (modulus == '0) ? MB'(1) : modulus;
                        acc_reg    <= MB'(1);
                        exp_reg    <= job.exponent_value;
                        mplier_reg <= job.base_value;
                        mcand_reg  <= MB'(1);
                        part_reg   <= '0;
                        cnt_reg    <= CB'(FB);
                        state_reg  <= S_RED;
                    end
                end
                S_RED, S_MUL, S_SQR:
                begin
                    part_reg   <= {1'b0, step_out};
                    mplier_reg <= {mplier_reg[FB-2:0], 1'b0};
                    cnt_reg    <= cnt_reg - CB'(1);
                    if (last_bit)
                    begin
                        if (state_reg == S_RED)
                        begin
                            pw_reg    <= step_out;
                            state_reg <= S_NEXT;
                        end
                        else if (state_reg == S_MUL)
                        begin
                            acc_reg    <= step_out;
                            part_reg   <= '0;
                            mcand_reg  <= pw_reg;
                            mplier_reg <= {{(FB-MB){1'b0}}, pw_reg};
                            cnt_reg    <= CB'(FB);
                            state_reg  <= S_SQR;
                        end
                        else
                        begin
                            pw_reg    <= step_out;
                            exp_reg   <= exp_reg >> 1;
                            state_reg <= S_NEXT;
                        end
                    end
                end
                S_NEXT:
                begin
                    part_reg <= '0;
                    cnt_reg  <= CB'(FB);
                    if (exp_reg == '0)
                        state_reg <= S_DONE;
                    else if (exp_reg[0])
                    begin
                        mcand_reg  <= acc_reg;
                        mplier_reg <= {{(FB-MB){1'b0}}, pw_reg};
                        state_reg  <= S_MUL;
                    end
                    else
                    begin
                        mcand_reg  <= pw_reg;
                        mplier_reg <= {{(FB-MB){1'b0}}, pw_reg};
                        state_reg  <= S_SQR;
                    end
                end
                S_DONE:
                begin
                    if (!res_valid_reg || out_ready)
                    begin
                        res_reg       <= acc_reg;
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_part_below_m: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL || state_reg == S_SQR) |-> part_reg < {1'b0, m_reg})
        else $error("partial product not reduced");
    a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && (!res_valid_reg || out_ready) |=> res_valid_reg)
        else $error("result not presented");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_ready |-> state_reg == S_IDLE) else $error("ready outside idle");

endmodule

[design/modular_exponentiation.sv]
// Per job: reduce the base, then for each exponent bit up to its highest set bit a multiply
// when the bit is set and a square; the result then goes to the output register.
// A new job leaves the queue only once the current one has passed its result to that register.
// A two-entry input queue accepts beats while a job runs; results wait in a register.
// Reset clears control state and sets the modulus to 2^31-1.
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Computes base^exponent mod modulus by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int OPERAND_BITS = modexp_pkg::OPERAND_BITS_D
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [modexp_pkg::MOD_BITS-1:0]  cfg_wdata,
    modexp_in_if.sink                        in_ch,
    modexp_out_if.source                     out_ch
);
    modexp_pkg::residue_t modulus_reg;
    modexp_pkg::job_t     in_job, job;
    logic                 job_valid, job_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= modexp_pkg::MODULUS_RESET;
        else if (cfg_we)
            modulus_reg <= cfg_wdata;
    end

    assign in_job.base_value     = in_ch.base_value;
    assign in_job.exponent_value = in_ch.exponent_value;

    modexp_front #(.OPERAND_BITS(OPERAND_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_job    (in_job),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    modexp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .modulus      (modulus_reg),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (job),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .power_result (out_ch.power_result)
    );

endmodule

[tb/modexp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation checker
// Watches the job and result channels, computes the expected power for each
// accepted job beat and compares every result beat with the oldest one.
// ----------------------------------------------------------------------------
module modexp_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [modexp_pkg::MOD_BITS-1:0]  cfg_wdata,
    modexp_in_if                             in_ch,
    modexp_out_if                            out_ch,
    output int                               error_count,
    output int                               pending_count
);
    modexp_pkg::residue_t modulus_q;
    modexp_pkg::residue_t expected_powers[$];

    function automatic modexp_pkg::residue_t power_mod(logic [31:0] base,
                                                       logic [31:0] expo,
                                                       modexp_pkg::residue_t m_in);
        logic [63:0] m;
        logic [63:0] acc;
        logic [63:0] pw;
        logic [31:0] e;
        m = (m_in == 0) ? 64'd1 : {33'd0, m_in};
        acc = 64'd1;
        pw = {32'd0, base} % m;
        e = expo;
        while (e != 0)
        begin
            if (e[0])
                acc = (acc * pw) % m;
            e = e >> 1;
            pw = (pw * pw) % m;
        end
        return acc[modexp_pkg::MOD_BITS-1:0];
    endfunction

    assign pending_count = expected_powers.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_q <= modexp_pkg::MODULUS_RESET;
            error_count <= 0;
            expected_powers.delete();
        end
        else
        begin
            if (cfg_we)
                modulus_q <= cfg_wdata;
            if (in_ch.valid && in_ch.ready)
                expected_powers.insert(expected_powers.size(),
                                       power_mod(in_ch.base_value,
                                                 in_ch.exponent_value, modulus_q));
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_powers.size() == 0)
                begin
                    $error("power_result: unexpected beat, actual %0d", out_ch.power_result);
                    error_count <= error_count + 1;
                end
                else if (expected_powers[0] !== out_ch.power_result)
                begin
                    $error("power_result: expected %0d, actual %0d",
                           expected_powers[0], out_ch.power_result);
                    error_count <= error_count + 1;
                    void'(expected_powers.pop_front());
                end
                else
                    void'(expected_powers.pop_front());
            end
        end
    end
endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives directed and random jobs across several modulus settings with random
// gaps and result stalls, including one long stall, and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
    localparam int RANDOM_JOBS = 252;
    localparam int CYCLE_LIMIT = 3000000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    modexp_pkg::residue_t cfg_wdata;
    int                   error_count;
    int                   pending_count;
    int                   cycle_count;
    bit                   long_hold;

    modexp_in_if  in_ch ();
    modexp_out_if out_ch ();

    modular_exponentiation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    modexp_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 120);
        return $urandom_range(0, 3);
    endfunction

    task automatic send_job(logic [31:0] base, logic [31:0] expo);
        int gap;
        gap = gap_length();
        repeat (gap)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.base_value <= base;
        in_ch.exponent_value <= expo;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (2200)
            @(negedge clk);
    endtask

    task automatic write_modulus(modexp_pkg::residue_t value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_exponent();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 15);
            1: return $urandom_range(0, 255);
            2: return $urandom_range(0, 65535);
            default: return $urandom();
        endcase
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        int hold;
        forever
        begin
            @(negedge clk);
            if (long_hold)
                out_ch.ready <= 1'b0;
            else if ($urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                hold = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 200)
                                                    : $urandom_range(0, 4);
                repeat (hold)
                    @(negedge clk);
                out_ch.ready <= 1'b1;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        modexp_pkg::residue_t moduli[6];
        cycle_count = 0;
        long_hold = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.base_value = '0;
        in_ch.exponent_value = '0;
        out_ch.ready = 1'b0;
        repeat (2)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_job(32'd0, 32'd0);
        send_job(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_job(32'd2, 32'd30);
        send_job(32'h7FFF_FFFF, 32'd5);
        send_job(32'h7FFF_FFFE, 32'd2);
        send_job(32'd3, 32'd0);
        send_job(32'd0, 32'd7);
        send_job(32'hAAAA_AAAA, 32'h5555_5555);
        send_job(32'h5555_5555, 32'hAAAA_AAAA);
        send_job(32'd1, 32'hFFFF_FFFF);
        send_job(32'h8000_0000, 32'h8000_0000);
        wait_idle();

        write_modulus(modexp_pkg::residue_t'(1));
        send_job(32'd5, 32'd0);
        send_job(32'd5, 32'd3);
        send_job(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_idle();
        write_modulus('0);
        send_job(32'd9, 32'd0);
        send_job(32'd9, 32'd9);
        wait_idle();
        write_modulus(modexp_pkg::residue_t'(13));
        send_job(32'd13, 32'd4);
        send_job(32'd12, 32'd3);
        send_job(32'hFFFF_FFFF, 32'd1);
        wait_idle();

        long_hold = 1'b1;
        fork
            begin
                repeat (6)
                    send_job($urandom(), $urandom_range(0, 31));
            end
            begin
                repeat (600)
                    @(negedge clk);
                long_hold = 1'b0;
            end
        join
        wait_idle();

        moduli[0] = modexp_pkg::MODULUS_RESET;
        moduli[1] = modexp_pkg::residue_t'(2);
        moduli[2] = modexp_pkg::residue_t'(1000003);
        moduli[3] = modexp_pkg::residue_t'(31'h4000_0000);
        moduli[4] = modexp_pkg::residue_t'(31'h7FFF_FFFE);
        moduli[5] = modexp_pkg::residue_t'(1);
        for (int p = 0; p < 6; p++)
        begin
            write_modulus(moduli[p]);
            for (int i = 0; i < RANDOM_JOBS / 6; i++)
                send_job($urandom(), rand_exponent());
            wait_idle();
        end
        write_modulus(modexp_pkg::residue_t'($urandom_range(1, 32'h7FFF_FFFF)));
        for (int i = 0; i < 15; i++)
            send_job($urandom(), rand_exponent());
        wait_idle();

        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule

[modular_exponentiation.f]
design/modexp_pkg.sv
design/modexp_if.sv
design/modexp_front.sv
design/modexp_back.sv
design/modular_exponentiation.sv
tb/modexp_checker.sv
tb/tb.sv
